[hw/rtl/source_text_tokenizer_top_assert.svh]
// Assertion macros used by the tokenizer checker.
`ifndef SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define STT_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("%s failed", "lbl");

// Next-cycle implication, held off during reset.
`define STT_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("%s failed", "lbl");

`endif

[hw/rtl/stt_pkg.sv]
package stt_pkg;

  localparam int unsigned OFFSET_BITS = 24;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
  localparam int unsigned MAX_RES = 3;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;
  localparam logic [2:0] MODE_OPER    = 3'd5;

  localparam logic [5:0] K_IDENT   = 6'd0;
  localparam logic [5:0] K_NUMBER  = 6'd1;
  localparam logic [5:0] K_STRING  = 6'd2;
  localparam logic [5:0] K_KEYWORD = 6'd3;
  localparam logic [5:0] K_NONE    = 6'd0;
  localparam logic [5:0] K_END     = 6'd34;
  localparam logic [5:0] K_BAD     = 6'd35;
  localparam logic [5:0] K_UNTERM  = 6'd36;

  localparam logic [2:0] KW_NONE = 3'd7;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [47:0] KW_IF     = 48'h6966;
  localparam logic [47:0] KW_ELSE   = 48'h656C7365;
  localparam logic [47:0] KW_WHILE  = 48'h7768696C65;
  localparam logic [47:0] KW_RETURN = 48'h72657475726E;
  localparam logic [47:0] KW_FUNC   = 48'h66756E63;
  localparam logic [47:0] KW_TRUE   = 48'h74727565;
  localparam logic [47:0] KW_FALSE  = 48'h66616C7365;

  typedef struct packed {
    logic [2:0]             mode;
    logic [7:0]             pending;
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] tstart;
    logic [47:0]            prefix;
  } state_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] start;
    logic [23:0] len;
    logic [2:0]  kw;
    logic [7:0]  bad;
    logic        last;
  } result_t;

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_name(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic logic is_held(logic [7:0] c);
    return c == CH_SLASH || c == CH_AMP || c == CH_BAR || c == CH_BANG ||
           c == CH_EQ || c == CH_LT || c == CH_GT;
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h2B:   k = 6'd4;
      8'h2D:   k = 6'd5;
      8'h2A:   k = 6'd6;
      8'h25:   k = 6'd7;
      8'h5E:   k = 6'd13;
      8'h28:   k = 6'd24;
      8'h29:   k = 6'd25;
      8'h5B:   k = 6'd26;
      8'h5D:   k = 6'd27;
      8'h7B:   k = 6'd28;
      8'h7D:   k = 6'd29;
      8'h3B:   k = 6'd30;
      8'h3A:   k = 6'd31;
      8'h2C:   k = 6'd32;
      8'h2E:   k = 6'd33;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] alone_kind(logic [7:0] p);
    logic [5:0] k;
    case (p)
      CH_SLASH: k = 6'd8;
      CH_AMP:   k = 6'd10;
      CH_BAR:   k = 6'd12;
      CH_BANG:  k = 6'd15;
      CH_EQ:    k = 6'd17;
      CH_LT:    k = 6'd20;
      default:  k = 6'd23;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(logic [7:0] p, logic [7:0] c);
    logic [5:0] k;
    k = K_NONE;
    if (p == CH_AMP && c == CH_AMP) k = 6'd9;
    else if (p == CH_BAR && c == CH_BAR) k = 6'd11;
    else if (p == CH_BANG && c == CH_EQ) k = 6'd14;
    else if (p == CH_EQ && c == CH_EQ) k = 6'd16;
    else if (p == CH_LT && c == CH_EQ) k = 6'd18;
    else if (p == CH_LT && c == CH_LT) k = 6'd19;
    else if (p == CH_GT && c == CH_EQ) k = 6'd21;
    else if (p == CH_GT && c == CH_GT) k = 6'd22;
    return k;
  endfunction

  function automatic logic [2:0] kw_index(logic [47:0] v);
    logic [2:0] i;
    if (v == KW_IF) i = 3'd0;
    else if (v == KW_ELSE) i = 3'd1;
    else if (v == KW_WHILE) i = 3'd2;
    else if (v == KW_RETURN) i = 3'd3;
    else if (v == KW_FUNC) i = 3'd4;
    else if (v == KW_TRUE) i = 3'd5;
    else if (v == KW_FALSE) i = 3'd6;
    else i = KW_NONE;
    return i;
  endfunction

  function automatic logic [47:0] add_prefix(logic [47:0] v, logic [7:0] c);
    return (v[47:40] != 8'd0) ? {48{1'b1}} : {v[39:0], c};
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sat_inc(logic [OFFSET_BITS-1:0] x);
    return (x == POS_MAX) ? x : x + 1'b1;
  endfunction

  function automatic logic [23:0] clip(logic [OFFSET_BITS-1:0] v);
    return (v > OFFSET_BITS'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(v);
  endfunction

  function automatic result_t mk(logic [5:0] kind, logic [OFFSET_BITS-1:0] start,
                                 logic [OFFSET_BITS-1:0] len, logic [2:0] kw,
                                 logic [7:0] bad);
    result_t r;
    r.kind  = kind;
    r.start = clip(start);
    r.len   = clip(len);
    r.kw    = kw;
    r.bad   = bad;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] span(logic [OFFSET_BITS-1:0] a,
                                                  logic [OFFSET_BITS-1:0] b);
    return (b > a) ? b - a : '0;
  endfunction

endpackage

[hw/rtl/stt_in_if.sv]
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       has_byte;
  logic       end_of_source;

  modport source (output valid, char_byte, has_byte, end_of_source, input ready);
  modport sink (input valid, char_byte, has_byte, end_of_source, output ready);
endinterface

[hw/rtl/stt_out_if.sv]
interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [23:0] start_offset;
  logic [23:0] lexeme_length;
  logic [2:0]  keyword_index;
  logic [7:0]  bad_char;
  logic        last_of_run;

  modport source (output valid, token_kind, start_offset, lexeme_length, keyword_index,
                  bad_char, last_of_run, input ready);
  modport sink (input valid, token_kind, start_offset, lexeme_length, keyword_index,
                bad_char, last_of_run, output ready);
endinterface

[hw/rtl/source_text_tokenizer_top.sv]
// Byte-serial source tokenizer.
// in_i carries one source byte per transfer (char_byte qualified by has_byte)
// and an end_of_source flag that closes the text after that byte.
// out_o carries tokens: kind, start offset, length, keyword index, the
// offending byte of a bad-character result, and last_of_run on the final
// token caused by one input transfer. An input may cause zero to three tokens.
// Tokens of an input are held in the result bank and appear in the cycle after its transfer.
// Throughput: one input per cycle while each input yields at most one token and
// the receiver does not stall; an input yielding more tokens holds off the next
// input while the single output port drains the bank, one token per ready cycle.
// The result bank acts as the output register: a new input is taken in the
// same cycle the last pending token of the previous one transfers.
// When the receiver stalls, tokens hold and in_i.ready drops once the bank
// cannot be freed in that cycle.
// Reset clears the scan state (idle, offset zero) and empties the bank.
// After an end-of-source input the scanner returns to its reset state.
module source_text_tokenizer_top (
  input logic      clk_i,
  input logic      rst_ni,
  stt_in_if.sink   in_i,
  stt_out_if.source out_o
);

  stt_pkg::state_t  state_q, state_d;
  stt_pkg::result_t bank_q [stt_pkg::MAX_RES];
  stt_pkg::result_t bank_d [stt_pkg::MAX_RES];
  logic [1:0]       cnt_q, cnt_d;
  logic [1:0]       idx_q;
  logic             in_xfer, out_xfer, out_valid, on_last;

  stt_step u_step (
    .state_i (state_q),
    .char_i  (in_i.char_byte),
    .has_i   (in_i.has_byte),
    .eos_i   (in_i.end_of_source),
    .state_o (state_d),
    .res_o   (bank_d),
    .count_o (cnt_d)
  );

  assign out_valid  = idx_q < cnt_q;
  assign on_last    = (idx_q + 2'd1) == cnt_q;
  // Accept when the bank is empty or its final token leaves this cycle.
  assign in_i.ready = !out_valid || (out_o.ready && on_last);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q   <= 2'd0;
      idx_q   <= 2'd0;
    end else if (in_xfer) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= 2'd0;
    end else if (out_xfer) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) bank_q <= bank_d;
  end

  assign out_o.valid         = out_valid;
  assign out_o.token_kind    = bank_q[idx_q].kind;
  assign out_o.start_offset  = bank_q[idx_q].start;
  assign out_o.lexeme_length = bank_q[idx_q].len;
  assign out_o.keyword_index = bank_q[idx_q].kw;
  assign out_o.bad_char      = bank_q[idx_q].bad;
  assign out_o.last_of_run   = bank_q[idx_q].last;

endmodule

[hw/rtl/stt_step.sv]
// Next-state and result logic for one source byte.
module stt_step (
  input  stt_pkg::state_t  state_i,
  input  logic [7:0]       char_i,
  input  logic             has_i,
  input  logic             eos_i,
  output stt_pkg::state_t  state_o,
  output stt_pkg::result_t res_o [stt_pkg::MAX_RES],
  output logic [1:0]       count_o
);

  stt_pkg::state_t  s;
  stt_pkg::result_t cand [4];
  logic [3:0]       cv;
  logic             do_begin;
  logic [5:0]       k;
  logic [stt_pkg::OFFSET_BITS-1:0] p;
  logic [1:0]       n;

  always_comb begin
    s        = state_i;
    p        = state_i.pos;
    cv       = '0;
    do_begin = 1'b0;
    k        = stt_pkg::K_NONE;
    for (int i = 0; i < 4; i++) begin
      cand[i] = stt_pkg::mk(stt_pkg::K_END, '0, '0, stt_pkg::KW_NONE, 8'd0);
    end

    if (has_i) begin
      case (state_i.mode)
        stt_pkg::MODE_IDENT: begin
          if (stt_pkg::is_name(char_i)) begin
            s.prefix = stt_pkg::add_prefix(state_i.prefix, char_i);
          end else begin
            cv[0]   = 1'b1;
            cand[0] = stt_pkg::mk((stt_pkg::kw_index(state_i.prefix) == stt_pkg::KW_NONE)
                                  ? stt_pkg::K_IDENT : stt_pkg::K_KEYWORD,
                                  state_i.tstart, stt_pkg::span(state_i.tstart, p),
                                  stt_pkg::kw_index(state_i.prefix), 8'd0);
            do_begin = 1'b1;
          end
        end
        stt_pkg::MODE_NUMBER: begin
          if (!stt_pkg::is_digit(char_i)) begin
            cv[0]    = 1'b1;
            cand[0]  = stt_pkg::mk(stt_pkg::K_NUMBER, state_i.tstart,
                                   stt_pkg::span(state_i.tstart, p), stt_pkg::KW_NONE, 8'd0);
            do_begin = 1'b1;
          end
        end
        stt_pkg::MODE_STRING: begin
          if (char_i == stt_pkg::CH_QUOTE) begin
            cv[0]   = 1'b1;
            cand[0] = stt_pkg::mk(stt_pkg::K_STRING, state_i.tstart,
                                  stt_pkg::span(state_i.tstart, p), stt_pkg::KW_NONE, 8'd0);
            s.mode  = stt_pkg::MODE_IDLE;
          end
        end
        stt_pkg::MODE_COMMENT: begin
          if (char_i == stt_pkg::CH_LF) s.mode = stt_pkg::MODE_IDLE;
        end
        stt_pkg::MODE_OPER: begin
          k = stt_pkg::pair_kind(state_i.pending, char_i);
          if (state_i.pending == stt_pkg::CH_SLASH && char_i == stt_pkg::CH_SLASH) begin
            s.mode = stt_pkg::MODE_COMMENT;
          end else if (k != stt_pkg::K_NONE) begin
            cv[0]   = 1'b1;
            cand[0] = stt_pkg::mk(k, state_i.tstart, stt_pkg::OFFSET_BITS'(2),
                                  stt_pkg::KW_NONE, 8'd0);
            s.mode  = stt_pkg::MODE_IDLE;
          end else begin
            cv[0]    = 1'b1;
            cand[0]  = stt_pkg::mk(stt_pkg::alone_kind(state_i.pending), state_i.tstart,
                                   stt_pkg::OFFSET_BITS'(1), stt_pkg::KW_NONE, 8'd0);
            do_begin = 1'b1;
          end
        end
        default: do_begin = 1'b1;
      endcase

      // Start a new token on the current byte.
      if (do_begin) begin
        s.mode = stt_pkg::MODE_IDLE;
        if (stt_pkg::is_space(char_i)) begin
          s.mode = stt_pkg::MODE_IDLE;
        end else if (char_i == stt_pkg::CH_QUOTE) begin
          s.mode   = stt_pkg::MODE_STRING;
          s.tstart = stt_pkg::sat_inc(p);
        end else if (stt_pkg::is_digit(char_i)) begin
          s.mode   = stt_pkg::MODE_NUMBER;
          s.tstart = p;
        end else if (stt_pkg::is_alpha(char_i) || char_i == stt_pkg::CH_UNDER) begin
          s.mode   = stt_pkg::MODE_IDENT;
          s.tstart = p;
          s.prefix = {40'd0, char_i};
        end else if (stt_pkg::is_held(char_i)) begin
          s.mode    = stt_pkg::MODE_OPER;
          s.pending = char_i;
          s.tstart  = p;
        end else if (stt_pkg::single_kind(char_i) != stt_pkg::K_NONE) begin
          cv[1]   = 1'b1;
          cand[1] = stt_pkg::mk(stt_pkg::single_kind(char_i), p, stt_pkg::OFFSET_BITS'(1),
                                stt_pkg::KW_NONE, 8'd0);
        end else begin
          cv[1]   = 1'b1;
          cand[1] = stt_pkg::mk(stt_pkg::K_BAD, p, stt_pkg::OFFSET_BITS'(1),
                                stt_pkg::KW_NONE, char_i);
        end
      end
      s.pos = stt_pkg::sat_inc(p);
    end

    if (eos_i) begin
      case (s.mode)
        stt_pkg::MODE_IDENT: begin
          cv[2]   = 1'b1;
          cand[2] = stt_pkg::mk((stt_pkg::kw_index(s.prefix) == stt_pkg::KW_NONE)
                                ? stt_pkg::K_IDENT : stt_pkg::K_KEYWORD,
                                s.tstart, stt_pkg::span(s.tstart, s.pos),
                                stt_pkg::kw_index(s.prefix), 8'd0);
        end
        stt_pkg::MODE_NUMBER: begin
          cv[2]   = 1'b1;
          cand[2] = stt_pkg::mk(stt_pkg::K_NUMBER, s.tstart, stt_pkg::span(s.tstart, s.pos),
                                stt_pkg::KW_NONE, 8'd0);
        end
        stt_pkg::MODE_STRING: begin
          cv[2]   = 1'b1;
          cand[2] = stt_pkg::mk(stt_pkg::K_UNTERM, s.tstart, stt_pkg::span(s.tstart, s.pos),
                                stt_pkg::KW_NONE, 8'd0);
        end
        stt_pkg::MODE_OPER: begin
          cv[2]   = 1'b1;
          cand[2] = stt_pkg::mk(stt_pkg::alone_kind(s.pending), s.tstart,
                                stt_pkg::OFFSET_BITS'(1), stt_pkg::KW_NONE, 8'd0);
        end
        default: cv[2] = 1'b0;
      endcase
      cv[3]   = 1'b1;
      cand[3] = stt_pkg::mk(stt_pkg::K_END, s.pos, '0, stt_pkg::KW_NONE, 8'd0);
      s       = '0;
    end
    state_o = s;
  end

  // Pack the valid candidates into the first slots and flag the last one.
  always_comb begin
    n = 2'd0;
    for (int j = 0; j < stt_pkg::MAX_RES; j++) begin
      res_o[j] = cand[3];
    end
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && n != 2'd3) begin
        res_o[n] = cand[i];
        n        = n + 2'd1;
      end
    end
    if (n != 2'd0) res_o[n - 2'd1].last = 1'b1;
    count_o = n;
  end

endmodule

[hw/rtl/stt_checker.sv]
`include "source_text_tokenizer_top_assert.svh"

module stt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [5:0]  token_kind_i,
  input logic [23:0] lexeme_length_i,
  input logic [2:0]  keyword_index_i,
  input logic        last_of_run_i
);

  `STT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `STT_ASSERT_IMP(a_kw_match, clk_i, rst_ni, out_valid_i,
                  (token_kind_i == stt_pkg::K_KEYWORD) == (keyword_index_i != stt_pkg::KW_NONE))
  `STT_ASSERT_IMP(a_end_tok, clk_i, rst_ni, out_valid_i && token_kind_i == stt_pkg::K_END,
                  lexeme_length_i == 24'd0 && last_of_run_i)
  `STT_ASSERT_IMP(a_kind_range, clk_i, rst_ni, out_valid_i, token_kind_i <= stt_pkg::K_UNTERM)

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .token_kind_i    (out_o.token_kind),
  .lexeme_length_i (out_o.lexeme_length),
  .keyword_index_i (out_o.keyword_index),
  .last_of_run_i   (out_o.last_of_run)
);
